// ===== rtl/brb_pkg.sv =====
// Shared constants, opcodes and helpers of the byte ring buffer with peek and release.
package brb_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RD_W   = $clog2(MAX_READ + 1);
  localparam int STEP_W = $clog2(ADDR_W);

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int AMOUNT_W  = 13;
  localparam int POS_W     = 12;

  localparam int IN_FIELDS_W  = BYTE_W + AMOUNT_W + POS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = BYTE_W + 13 + 12 + 12 + 13 + 13;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_W        = 13;

  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_RD_HEAD = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_POS  = 2'd3;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p,
                                                 input logic [CNT_W-1:0] rs);
    logic [CNT_W-1:0] s;
    s = CNT_W'(p) + CNT_W'(1);
    return (s >= rs) ? '0 : s[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/byte_ring_buffer_peek_release_unit.sv =====
// Top level of the byte ring buffer with peek and release: store, pointers and read sequencer.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_tvalid / in_tready  | in_tuser opcode, in_tdata byte/amount/pos
//  out     | out_tvalid / out_tready| out_tuser byte_valid, out_tlast, out_tdata
//  cfg     | cfg_valid / cfg_ready  | cfg_data ring_size
//
// Push and release: accepted in S_IDLE, executed in S_CMD. Head read: n bytes at one
// per cycle, unless the output stalls, through the single read port of the store.
// Positional read: first the bit-per-cycle remainder of position by ring_size in S_MOD.
// Reset clears pointers and fill and sets ring_size to 4096; store content is not cleared.
// An output stall holds the read sequencer; the store address is re-issued until taken.
module byte_ring_buffer_peek_release_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brb_pkg::IN_DATA_W-1:0]  in_tdata,   // data_byte, amount, position
  input  logic [brb_pkg::OP_W-1:0]       in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_byte, done_count, next_position, head_index, fill_count, free_space
  output logic [brb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // byte_valid
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [brb_pkg::CFG_W-1:0]      cfg_data    // ring_size
);
  import brb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMD  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [AMOUNT_W-1:0] amt_r, amt_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    rs_r, rs_nxt;
  logic [ADDR_W-1:0]   p_r, p_nxt;
  logic [RD_W-1:0]     n_r, n_nxt;
  logic [RD_W-1:0]     cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_bv_r, out_bv_nxt;
  logic [CNT_W-1:0]    out_done_r, out_done_nxt;
  logic [ADDR_W-1:0]   out_next_r, out_next_nxt;
  logic [ADDR_W-1:0]   out_head_r, out_head_nxt;
  logic [CNT_W-1:0]    out_fill_r, out_fill_nxt;
  logic [CNT_W-1:0]    out_free_r, out_free_nxt;
  logic                out_last_r, out_last_nxt;

  logic [BYTE_W-1:0]   mem [DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [BYTE_W-1:0]   mem_q;

  logic                in_acc, cfg_acc, out_free;
  logic [ADDR_W-1:0]   inc_p, inc_tail;
  logic [CNT_W-1:0]    rem_sh, rem_sub;
  logic [ADDR_W-1:0]   rem_new;
  logic [CNT_W-1:0]    hmin, n_full;
  logic [RD_W-1:0]     n_sat;
  logic [CNT_W-1:0]    rel_n, rel_held, rel_sum, rel_sub;
  logic [ADDR_W-1:0]   rel_head;
  logic [CNT_W-1:0]    cfg_clamp;
  logic                rd_last;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_free_r, out_fill_r, out_head_r, out_next_r,
                                   out_done_r, out_byte_r});

  assign inc_p    = wrap_inc(p_r, rs_r);
  assign inc_tail = wrap_inc(tail_r, rs_r);

  assign rem_sh  = {rem_r, pos_r[POS_W-1]};
  assign rem_sub = rem_sh - rs_r;
  assign rem_new = (rem_sh >= rs_r) ? rem_sub[ADDR_W-1:0] : rem_sh[ADDR_W-1:0];

  assign hmin   = (amt_r > held_r) ? held_r : amt_r;
  assign n_full = (held_r == '0) ? '0 : ((op_r == OP_RD_HEAD) ? hmin : amt_r);
  assign n_sat  = (n_full > CNT_W'(MAX_READ)) ? RD_W'(MAX_READ) : n_full[RD_W-1:0];

  assign rel_n    = (held_r == '0 || amt_r == '0) ? '0 : hmin;
  assign rel_held = held_r - rel_n;
  assign rel_sum  = CNT_W'(head_r) + amt_r;
  assign rel_sub  = rel_sum - rs_r;
  assign rel_head = (rel_n == '0) ? head_r :
                    (amt_r >= held_r) ? tail_r :
                    (rel_sum >= rs_r) ? rel_sub[ADDR_W-1:0] : rel_sum[ADDR_W-1:0];

  assign cfg_clamp = (cfg_data == '0) ? CNT_W'(1) :
                     (cfg_data > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_data;

  assign rd_last   = ((cnt_r + RD_W'(1)) == n_r);
  assign mem_we    = (state_r == S_CMD) && (op_r == OP_PUSH) && out_free && (held_r < rs_r);
  assign mem_raddr = (pend_r && out_free) ? inc_p : p_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= data_r;
    end
    mem_q <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    data_nxt      = data_r;
    amt_nxt       = amt_r;
    pos_nxt       = pos_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    rs_nxt        = rs_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_done_nxt  = out_done_r;
    out_next_nxt  = out_next_r;
    out_head_nxt  = out_head_r;
    out_fill_nxt  = out_fill_r;
    out_free_nxt  = out_free_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          data_nxt  = in_tdata[BYTE_W-1:0];
          amt_nxt   = in_tdata[BYTE_W +: AMOUNT_W];
          pos_nxt   = in_tdata[BYTE_W+AMOUNT_W +: POS_W];
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        unique case (op_r)
          OP_PUSH: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_bv_nxt    = 1'b0;
              out_last_nxt  = 1'b1;
              out_head_nxt  = head_r;
              if (held_r < rs_r) begin
                tail_nxt     = inc_tail;
                held_nxt     = held_r + CNT_W'(1);
                out_done_nxt = CNT_W'(1);
                out_next_nxt = inc_tail;
                out_fill_nxt = held_r + CNT_W'(1);
                out_free_nxt = rs_r - held_r - CNT_W'(1);
              end else begin
                out_done_nxt = '0;
                out_next_nxt = tail_r;
                out_fill_nxt = held_r;
                out_free_nxt = rs_r - held_r;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_RELEASE: begin
            if (out_free) begin
              head_nxt      = rel_head;
              held_nxt      = rel_held;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_bv_nxt    = 1'b0;
              out_last_nxt  = 1'b1;
              out_done_nxt  = rel_n;
              out_next_nxt  = rel_head;
              out_head_nxt  = rel_head;
              out_fill_nxt  = rel_held;
              out_free_nxt  = rs_r - rel_held;
              state_nxt     = S_IDLE;
            end
          end
          OP_RD_HEAD: begin
            p_nxt     = head_r;
            n_nxt     = n_sat;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_RD;
          end
          OP_RD_POS: begin
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_MOD;
          end
        endcase
      end
      S_MOD: begin
        rem_nxt  = rem_new;
        pos_nxt  = {pos_r[POS_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ADDR_W - 1)) begin
          p_nxt     = rem_new;
          n_nxt     = n_sat;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (n_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_bv_nxt    = 1'b0;
            out_done_nxt  = '0;
            out_next_nxt  = p_r;
            out_head_nxt  = head_r;
            out_fill_nxt  = held_r;
            out_free_nxt  = rs_r - held_r;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (!pend_r) begin
          pend_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mem_q;
          out_bv_nxt    = 1'b1;
          out_done_nxt  = CNT_W'(n_r);
          out_next_nxt  = inc_p;
          out_head_nxt  = head_r;
          out_fill_nxt  = held_r;
          out_free_nxt  = rs_r - held_r;
          out_last_nxt  = rd_last;
          p_nxt         = inc_p;
          cnt_nxt       = cnt_r + RD_W'(1);
          if (rd_last) begin
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
    endcase

    if (cfg_acc) begin
      rs_nxt   = cfg_clamp;
      head_nxt = '0;
      tail_nxt = '0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      rs_r        <= CNT_W'(DEPTH);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      rs_r        <= rs_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    data_r     <= data_nxt;
    amt_r      <= amt_nxt;
    pos_r      <= pos_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_done_r <= out_done_nxt;
    out_next_r <= out_next_nxt;
    out_head_r <= out_head_nxt;
    out_fill_r <= out_fill_nxt;
    out_free_r <= out_free_nxt;
    out_last_r <= out_last_nxt;
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= rs_r) else $error("fill exceeds ring size");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(head_r) < rs_r) else $error("head outside ring");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0 || held_r == rs_r) |-> head_r == tail_r)
    else $error("head and tail disagree with fill");

  a_rd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && n_r != '0) |-> cnt_r < n_r)
    else $error("read sequencer overran its length");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !pend_r) else $error("store written during a read");

endmodule

// ===== tb/byte_ring_buffer_peek_release_unit_tb.sv =====
// Self-checking testbench of the byte ring buffer with peek and release, with a ring predictor.
module byte_ring_buffer_peek_release_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 100;
  localparam int AMOUNT_MAX    = 4096;

  typedef struct {
    logic [7:0]  rd_byte;
    logic        byte_valid;
    logic [12:0] done;
    logic [11:0] next_pos;
    logic [11:0] head;
    logic [12:0] fill;
    logic [12:0] space;
    logic        last;
  } ring_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // data_byte, amount, position
  logic [OP_W-1:0]       in_tuser;   // opcode
  logic                  out_tvalid;
  logic                  out_tready;
  // out_byte, done_count, next_position, head_index, fill_count, free_space
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;  // byte_valid
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;   // ring_size

  logic [7:0]   ring_mem [DEPTH];
  bit           ring_written [DEPTH];
  int unsigned  ring_len;
  int unsigned  ring_head;
  int unsigned  ring_tail;
  int unsigned  ring_fill;
  ring_result_t expected_results [$];
  int unsigned  mismatches;
  int unsigned  recv_stall;
  bit           send_gaps;
  bit           recv_gaps;
  bit           out_hold;
  event         hold_ev;

  byte_ring_buffer_peek_release_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= ring_len) ? 0 : p + 1;
  endfunction

  task automatic apply_ring_size(input int unsigned value);
    int unsigned v;
    v = value & 32'h1FFF;
    if (v == 0) v = 1;
    if (v > DEPTH) v = DEPTH;
    ring_len  = v;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
  endtask

  task automatic expect_result(input logic [7:0] b, input logic v, input int unsigned done,
                               input int unsigned next, input logic lastmark);
    ring_result_t r;
    r.rd_byte    = b;
    r.byte_valid = v;
    r.done       = 13'(done);
    r.next_pos   = 12'(next);
    r.head       = 12'(ring_head);
    r.fill       = 13'(ring_fill);
    r.space      = 13'(ring_len - ring_fill);
    r.last       = lastmark;
    expected_results.push_back(r);
  endtask

  task automatic expect_read(input int unsigned start, input int unsigned n);
    int unsigned p;
    int unsigned cnt;
    logic [7:0]  b;
    if (n == 0) begin
      expect_result(8'd0, 1'b0, 0, start, 1'b1);
      return;
    end
    cnt = (n > MAX_READ) ? MAX_READ : n;
    p = start;
    for (int unsigned i = 0; i < cnt; i++) begin
      b = ring_mem[p];
      p = ring_next(p);
      expect_result(b, 1'b1, cnt, p, i + 1 == cnt);
    end
  endtask

  task automatic predict_request(input logic [OP_W-1:0] op, input logic [7:0] data,
                                 input int unsigned amount, input int unsigned pos);
    int unsigned n;
    case (op)
      OP_PUSH: begin
        if (ring_fill < ring_len) begin
          ring_mem[ring_tail]     = data;
          ring_written[ring_tail] = 1'b1;
          ring_tail = ring_next(ring_tail);
          ring_fill++;
          expect_result(8'd0, 1'b0, 1, ring_tail, 1'b1);
        end else begin
          expect_result(8'd0, 1'b0, 0, ring_tail, 1'b1);
        end
      end
      OP_RELEASE: begin
        n = 0;
        if (ring_fill != 0 && amount != 0) begin
          if (amount >= ring_fill) begin
            n = ring_fill;
            ring_head = ring_tail;
            ring_fill = 0;
          end else begin
            n = amount;
            ring_head += n;
            if (ring_head >= ring_len) ring_head -= ring_len;
            ring_fill -= n;
          end
        end
        expect_result(8'd0, 1'b0, n, ring_head, 1'b1);
      end
      OP_RD_HEAD: begin
        n = (ring_fill == 0) ? 0 : amount;
        if (n > ring_fill) n = ring_fill;
        expect_read(ring_head, n);
      end
      default: begin
        n = (ring_fill == 0) ? 0 : amount;
        expect_read(pos % ring_len, n);
      end
    endcase
  endtask

  // never let a positional read touch a store entry that was not written
  function automatic bit pos_read_safe(input int unsigned pos, input int unsigned amount);
    int unsigned p;
    int unsigned cnt;
    if (ring_fill == 0) return 1'b1;
    cnt = (amount > MAX_READ) ? MAX_READ : amount;
    p = pos % ring_len;
    for (int unsigned i = 0; i < cnt; i++) begin
      if (!ring_written[p]) return 1'b0;
      p = ring_next(p);
    end
    return 1'b1;
  endfunction

  function automatic int unsigned random_amount();
    case ($urandom_range(0, 7))
      0: return 0;
      5: return $urandom_range(1, MAX_READ);
      6: return $urandom_range(MAX_READ + 1, AMOUNT_MAX);
      7: return AMOUNT_MAX;
      default: return $urandom_range(1, ring_fill + 3);
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] data,
                              input logic [12:0] amount, input logic [11:0] pos);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({pos, amount, data});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(op, data, amount, pos);
  endtask

  task automatic send_random_op();
    int unsigned pick;
    int unsigned amount;
    int unsigned pos;
    int unsigned off;
    logic [OP_W-1:0] op;
    logic [7:0] data;
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? OP_PUSH : (pick < 55) ? OP_RELEASE : (pick < 75) ? OP_RD_HEAD : OP_RD_POS;
    data = 8'($urandom_range(0, 255));
    amount = random_amount();
    pos = $urandom_range(0, DEPTH - 1);
    if (op == OP_RD_POS) begin
      for (int i = 0; i < 6 && !pos_read_safe(pos, amount); i++)
        pos = $urandom_range(0, DEPTH - 1);
      if (!pos_read_safe(pos, amount)) begin
        off = $urandom_range(0, ring_fill - 1);
        pos = (ring_head + off) % ring_len;
        pos += ring_len * $urandom_range(0, (DEPTH - 1 - pos) / ring_len);
        if (!pos_read_safe(pos, amount)) amount = $urandom_range(1, ring_fill - off);
      end
    end
    send_request(op, data, 13'(amount), 12'(pos));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_ring_size(value);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual tdata %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", want.rd_byte, out_tdata[7:0]);
        check_field("byte_valid", want.byte_valid, out_tuser);
        check_field("done_count", want.done, out_tdata[20:8]);
        check_field("next_position", want.next_pos, out_tdata[32:21]);
        check_field("head_index", want.head, out_tdata[44:33]);
        check_field("fill_count", want.fill, out_tdata[57:45]);
        check_field("free_space", want.space, out_tdata[70:58]);
        check_field("last", want.last, out_tlast);
      end
    end
    if (out_hold) begin
      out_tready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(hold_ev);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  task automatic test_directed();
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd5, 12'd0);
    send_request(OP_RD_POS, 8'($urandom_range(0, 255)), 13'd4096, 12'd4095);
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 13'd4096, 12'd0);
    send_request(OP_PUSH, 8'h00, 13'd0, 12'd0);
    send_request(OP_PUSH, 8'hFF, 13'd0, 12'd0);
    send_request(OP_PUSH, 8'hA5, 13'd0, 12'd0);
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 13'd0, 12'd0);
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd0, 12'd0);
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd4096, 12'd0);
    send_request(OP_RD_POS, 8'($urandom_range(0, 255)), 13'd2, 12'd1);
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 13'd1, 12'd0);
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 13'd4096, 12'd0);
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd1, 12'd0);
    write_ring_size(13'd4);
    for (int i = 0; i < 5; i++)
      send_request(OP_PUSH, 8'(8'h11 * (i + 1)), 13'd0, 12'd0);
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd64, 12'd0);
    send_request(OP_RD_POS, 8'($urandom_range(0, 255)), 13'd100, 12'd4095);
    send_request(OP_RELEASE, 8'($urandom_range(0, 255)), 13'd3, 12'd0);
    send_request(OP_PUSH, 8'h5A, 13'd0, 12'd0);
    send_request(OP_PUSH, 8'hC3, 13'd0, 12'd0);
    send_request(OP_RD_HEAD, 8'($urandom_range(0, 255)), 13'd3, 12'd0);
    send_request(OP_RD_POS, 8'($urandom_range(0, 255)), 13'd0, 12'd0);
  endtask

  task automatic test_ring_sizes();
    int ring_plan [10] = '{1, 2, 7, 0, 64, 8191, 100, 4095, 3, 4096};
    foreach (ring_plan[k]) begin
      write_ring_size(13'(ring_plan[k]));
      repeat (30) send_random_op();
    end
  endtask

  task automatic test_output_stall();
    write_ring_size(13'd64);
    repeat (20) send_request(OP_PUSH, 8'($urandom_range(0, 255)), 13'd0, 12'd0);
    -> hold_ev;
    send_gaps = 1'b0;
    repeat (40) send_random_op();
    send_gaps = 1'b1;
    drain_results();
  endtask

  task automatic test_no_gaps();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    write_ring_size(13'd16);
    repeat (40) send_random_op();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    send_gaps  = 1'b1;
    recv_gaps  = 1'b1;
    recv_stall = 0;
    mismatches = 0;
    apply_ring_size(DEPTH);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_ring_sizes();
    test_output_stall();
    test_no_gaps();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
